[rtl/ssht_pkg.sv]
`timescale 1ns / 1ps
package ssht_pkg;
   localparam int SLOTS_DEFAULT       = 64;
   localparam int STACK_DEPTH_DEFAULT = 4;
   localparam int MAX_NAME_DEFAULT    = 12;
   localparam logic [31:0] HASH_SEED  = 32'd7;
   localparam logic [31:0] HASH_MULT  = 32'd31;

   typedef enum logic [1:0] {
      CMD_INSERT = 2'd0,
      CMD_LOOKUP = 2'd1,
      CMD_CLEAR  = 2'd2,
      CMD_NOP    = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_FULL      = 2'd2,
      ST_OVERFLOW  = 2'd3
   } status_type;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [63:0] name_low;
      logic [31:0] name_high;
      logic [3:0]  name_length;
      logic [7:0]  scope_level;
      logic [31:0] handle;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] found_handle;
   } rsp_type;

   // Hash unit handshake
   typedef struct packed {
      logic        start;
      logic [63:0] name_low;
      logic [31:0] name_high;
      logic [3:0]  name_length;
   } hash_req_type;

   typedef struct packed {
      logic        done;
      logic [31:0] hash;
      logic [63:0] name_low;
      logic [31:0] name_high;
   } hash_rsp_type;
endpackage

[rtl/ssht_if.sv]
`timescale 1ns / 1ps
interface ssht_req_if;
   logic              valid;
   logic              ready;
   ssht_pkg::req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface ssht_rsp_if;
   logic              valid;
   logic              ready;
   ssht_pkg::rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

[rtl/ssht_hash.sv]
`timescale 1ns / 1ps
// Name normalization and hash, one character per cycle.
module ssht_hash #(
   parameter int MAX_NAME = ssht_pkg::MAX_NAME_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  ssht_pkg::hash_req_type hreq,
   output ssht_pkg::hash_rsp_type hrsp
);
   logic [95:0] name_ff, name_in;
   logic [3:0]  len_ff, len_in;
   logic [3:0]  idx_ff, idx_in;
   logic [31:0] h_ff, h_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [7:0]  ch;
   logic [3:0]  lim;

   assign ch  = name_ff[8*idx_ff +: 8];
   assign lim = (hreq.name_length > 4'(MAX_NAME)) ? 4'(MAX_NAME) : hreq.name_length;

   always_comb begin
      name_in = name_ff;
      len_in  = len_ff;
      idx_in  = idx_ff;
      h_in    = h_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (hreq.start) begin
         name_in = {hreq.name_high, hreq.name_low};
         len_in  = lim;
         idx_in  = '0;
         h_in    = ssht_pkg::HASH_SEED;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (idx_ff >= len_ff || ch == 8'd0) begin
            // mask characters at and past the effective end
            for (int i = 0; i < 12; i++) begin
               if (4'(i) >= idx_ff) name_in[8*i +: 8] = 8'd0;
            end
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            h_in   = h_ff * ssht_pkg::HASH_MULT + {24'd0, ch};
            idx_in = idx_ff + 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      name_ff <= name_in;
      len_ff  <= len_in;
      idx_ff  <= idx_in;
      h_ff    <= h_in;
   end

   assign hrsp.done      = done_ff;
   assign hrsp.hash      = h_ff;
   assign hrsp.name_low  = name_ff[63:0];
   assign hrsp.name_high = name_ff[95:64];
endmodule

[rtl/ssht_top.sv]
`timescale 1ns / 1ps
// Table engine: slot memory and entry memory, sequenced probe and sweep.
module ssht_top #(
   parameter int SLOTS       = ssht_pkg::SLOTS_DEFAULT,
   parameter int STACK_DEPTH = ssht_pkg::STACK_DEPTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  ssht_pkg::req_type      req,
   input  ssht_pkg::hash_rsp_type hrsp,
   output logic                   done,
   output ssht_pkg::rsp_type      rsp
);
   localparam int SW = $clog2(SLOTS);
   localparam int DW = $clog2(STACK_DEPTH) > 0 ? $clog2(STACK_DEPTH) : 1;
   localparam int CW = $clog2(STACK_DEPTH + 1);
   localparam int EW = SW + DW;
   localparam int SLOT_W = CW + 96;
   localparam int ENT_W  = 40;

   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_HASH  = 7'b0000010,
      S_PROBE = 7'b0000100,
      S_CHECK = 7'b0001000,
      S_ERD   = 7'b0010000,
      S_ECHK  = 7'b0100000,
      S_DONE  = 7'b1000000
   } state_type;

   // slot memory: {count, name_high, name_low}; count of zero marks empty
   // entry memory: indexed {slot, stack position}
   logic [SLOT_W-1:0] slot_mem [SLOTS];
   logic [ENT_W-1:0]  ent_mem  [SLOTS << DW];
   logic [SLOTS-1:0]  slot_vld_ff;
   logic [SLOT_W-1:0] slot_rd_ff;
   logic [ENT_W-1:0]  ent_rd_ff;

   state_type   state_ff, state_in;
   logic [SW-1:0] addr_ff, addr_in;
   logic [SW:0]   cnt_ff, cnt_in;
   logic          have_empty_ff, have_empty_in;
   logic [SW-1:0] empty_ff, empty_in;
   logic [95:0]   name_ff, name_in;
   logic [1:0]    status_ff, status_in;
   logic [31:0]   found_ff, found_in;

   logic          s_we, e_we, s_re, e_re;
   logic [SW-1:0] s_waddr, s_raddr;
   logic [SLOT_W-1:0] s_wdata;
   logic [EW-1:0] e_waddr, e_raddr;
   logic [ENT_W-1:0] e_wdata;

   logic [CW-1:0] rd_cnt;
   logic          rd_live, rd_match;
   logic [DW-1:0] top_idx;

   assign rd_cnt   = slot_vld_ff[addr_ff] ? slot_rd_ff[SLOT_W-1 -: CW] : '0;
   assign rd_live  = rd_cnt != '0;
   assign rd_match = rd_live && slot_rd_ff[95:0] == name_ff;
   assign top_idx  = DW'(rd_cnt - CW'(1));

   always_ff @(posedge clock) begin
      if (s_we) slot_mem[s_waddr] <= s_wdata;
      if (s_re) slot_rd_ff <= slot_mem[s_raddr];
      if (e_we) ent_mem[e_waddr] <= e_wdata;
      if (e_re) ent_rd_ff <= ent_mem[e_raddr];
   end

   always_comb begin
      state_in      = state_ff;
      addr_in       = addr_ff;
      cnt_in        = cnt_ff;
      have_empty_in = have_empty_ff;
      empty_in      = empty_ff;
      name_in       = name_ff;
      status_in     = status_ff;
      found_in      = found_ff;
      s_we = 1'b0; e_we = 1'b0; s_re = 1'b0; e_re = 1'b0;
      s_waddr = addr_ff; s_raddr = addr_ff;
      s_wdata = slot_rd_ff;
      e_waddr = {addr_ff, top_idx}; e_raddr = {addr_ff, top_idx};
      e_wdata = {req.scope_level, req.handle};
      done = 1'b0;
      unique case (state_ff)
         S_IDLE: if (start) begin
            status_in = ssht_pkg::ST_OK;
            found_in  = '0;
            have_empty_in = 1'b0;
            cnt_in = '0;
            if (req.cmd == ssht_pkg::CMD_CLEAR) begin
               addr_in  = '0;
               s_re = 1'b1; s_raddr = '0;
               state_in = S_CHECK;
            end else if (req.cmd == ssht_pkg::CMD_NOP) begin
               state_in = S_DONE;
            end else begin
               state_in = S_HASH;
            end
         end
         S_HASH: if (hrsp.done) begin
            name_in = {hrsp.name_high, hrsp.name_low};
            addr_in = SW'(hrsp.hash % SLOTS);
            s_re = 1'b1; s_raddr = SW'(hrsp.hash % SLOTS);
            state_in = S_PROBE;
         end
         S_PROBE: begin
            // slot_rd_ff valid; probe step
            cnt_in = cnt_ff + 1'b1;
            if (rd_match) begin
               if (req.cmd == ssht_pkg::CMD_LOOKUP) begin
                  e_re = 1'b1;
                  state_in = S_ERD;
               end else if (rd_cnt >= CW'(STACK_DEPTH)) begin
                  status_in = ssht_pkg::ST_OVERFLOW;
                  state_in = S_DONE;
               end else begin
                  s_we = 1'b1;
                  s_wdata = {rd_cnt + CW'(1), name_ff};
                  e_we = 1'b1; e_waddr = {addr_ff, DW'(rd_cnt)};
                  state_in = S_DONE;
               end
            end else begin
               if (!rd_live && !have_empty_ff) begin
                  have_empty_in = 1'b1;
                  empty_in = addr_ff;
               end
               if (cnt_ff == (SW+1)'(SLOTS - 1)) begin
                  if (req.cmd == ssht_pkg::CMD_LOOKUP) begin
                     status_in = ssht_pkg::ST_NOT_FOUND;
                  end else if (have_empty_ff || !rd_live) begin
                     s_we = 1'b1;
                     s_waddr = have_empty_ff ? empty_ff : addr_ff;
                     s_wdata = {CW'(1), name_ff};
                     e_we = 1'b1;
                     e_waddr = {have_empty_ff ? empty_ff : addr_ff, DW'(0)};
                  end else begin
                     status_in = ssht_pkg::ST_FULL;
                  end
                  state_in = S_DONE;
               end else begin
                  addr_in = SW'((SW+1)'(addr_ff) + 1'b1 == (SW+1)'(SLOTS) ? 0
                                : addr_ff + 1'b1);
                  s_re = 1'b1; s_raddr = addr_in;
               end
            end
         end
         S_ERD: begin
            found_in = ent_rd_ff[31:0];
            state_in = S_DONE;
         end
         S_CHECK: begin
            // clear sweep: slot read back, fetch its top entry
            if (rd_live) begin
               e_re = 1'b1;
               state_in = S_ECHK;
            end else if (addr_ff == SW'(SLOTS - 1)) begin
               state_in = S_DONE;
            end else begin
               addr_in = addr_ff + 1'b1;
               s_re = 1'b1; s_raddr = addr_ff + 1'b1;
            end
         end
         S_ECHK: begin
            if (ent_rd_ff[39:32] == req.scope_level) begin
               s_we = 1'b1;
               s_wdata = {rd_cnt - CW'(1), slot_rd_ff[95:0]};
            end
            if (addr_ff == SW'(SLOTS - 1)) begin
               state_in = S_DONE;
            end else begin
               addr_in = addr_ff + 1'b1;
               s_re = 1'b1; s_raddr = addr_ff + 1'b1;
               state_in = S_CHECK;
            end
         end
         S_DONE: begin
            done = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         slot_vld_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (s_we) slot_vld_ff[s_waddr] <= 1'b1;
      end
      addr_ff       <= addr_in;
      cnt_ff        <= cnt_in;
      have_empty_ff <= have_empty_in;
      empty_ff      <= empty_in;
      name_ff       <= name_in;
      status_ff     <= status_in;
      found_ff      <= found_in;
   end

   assign rsp.status       = status_ff;
   assign rsp.found_handle = found_ff;
endmodule

[rtl/scoped_symbol_hash_table_top.sv]
`timescale 1ns / 1ps
// Channel | Dir | Payload                                      | Handshake
// req     | in  | cmd, name_low/high, name_length, level, handle | valid/ready
// rsp     | out | status, found_handle                           | valid/ready
// One transaction at a time: the hash walks the name to its effective length,
// then insert/lookup probe one slot per cycle (up to SLOTS), clear sweeps all
// SLOTS slots and reads each live slot's top entry (read port sets the rate).
// Synchronous active-high reset empties the table at once (per-slot valid).
// A result held by a stalled rsp leaves the next transaction waiting in req.
module scoped_symbol_hash_table_top #(
   parameter int SLOTS       = ssht_pkg::SLOTS_DEFAULT,
   parameter int STACK_DEPTH = ssht_pkg::STACK_DEPTH_DEFAULT,
   parameter int MAX_NAME    = ssht_pkg::MAX_NAME_DEFAULT
) (
   input logic       clock,
   input logic       reset,
   ssht_req_if.sink  req,
   ssht_rsp_if.source rsp
);
   logic                   busy_ff, busy_in;
   logic                   out_vld_ff, out_vld_in;
   ssht_pkg::req_type      cur_ff;
   ssht_pkg::rsp_type      out_ff;
   ssht_pkg::rsp_type      eng_rsp;
   ssht_pkg::hash_req_type hreq;
   ssht_pkg::hash_rsp_type hrsp;
   logic                   eng_done, take;

   // accept only when engine idle and result slot free
   assign req.ready = !busy_ff && !out_vld_ff;
   assign take      = req.valid && req.ready;

   assign hreq.start       = take;
   assign hreq.name_low    = req.payload.name_low;
   assign hreq.name_high   = req.payload.name_high;
   assign hreq.name_length = req.payload.name_length;

   ssht_hash #(.MAX_NAME(MAX_NAME)) u_hash (
      .clock(clock), .reset(reset), .hreq(hreq), .hrsp(hrsp));

   ssht_top #(.SLOTS(SLOTS), .STACK_DEPTH(STACK_DEPTH)) u_eng (
      .clock(clock), .reset(reset), .start(take), .req(take ? req.payload : cur_ff),
      .hrsp(hrsp), .done(eng_done), .rsp(eng_rsp));

   always_comb begin
      busy_in    = busy_ff;
      out_vld_in = out_vld_ff;
      if (take) busy_in = 1'b1;
      if (eng_done) begin
         busy_in    = 1'b0;
         out_vld_in = 1'b1;
      end else if (rsp.ready) begin
         out_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff    <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         busy_ff    <= busy_in;
         out_vld_ff <= out_vld_in;
      end
      if (take) cur_ff <= req.payload;
      if (eng_done) out_ff <= eng_rsp;
   end

   assign rsp.valid   = out_vld_ff;
   assign rsp.payload = out_ff;

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !req.ready) else $error("accept while busy");
   a_done_busy: assert property (@(posedge clock) disable iff (reset)
      eng_done |-> busy_ff) else $error("done while idle");
   a_found_zero: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.payload.status != ssht_pkg::ST_OK |->
      rsp.payload.found_handle == '0) else $error("handle on failure");
endmodule

[dv/ssht_tb_if.sv]
`timescale 1ns / 1ps
// Passive tap on both channels for the checker.
interface ssht_tap_if;
   logic              req_valid;
   logic              req_ready;
   ssht_pkg::req_type req_payload;
   logic              rsp_valid;
   logic              rsp_ready;
   ssht_pkg::rsp_type rsp_payload;
   modport source (output req_valid, req_ready, req_payload,
                   output rsp_valid, rsp_ready, rsp_payload);
   modport sink   (input req_valid, req_ready, req_payload,
                   input rsp_valid, rsp_ready, rsp_payload);
endinterface

[dv/ssht_checker.sv]
`timescale 1ns / 1ps
module ssht_checker
   import ssht_pkg::*;
#(
   parameter int SLOTS = 64,
   parameter int DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   ssht_tap_if.sink    tap,
   output int          fail_count,
   output int          pending
);
   int unsigned       occupancy [SLOTS];
   logic [63:0]       key_low   [SLOTS];
   logic [31:0]       key_high  [SLOTS];
   logic [7:0]        lvl       [SLOTS][DEPTH];
   logic [31:0]       hnd       [SLOTS][DEPTH];
   rsp_type           expected_q[$];

   function automatic logic [7:0] char_of(logic [63:0] lo, logic [31:0] hi, int i);
      if (i < 8) return lo[8*i +: 8];
      return hi[8*(i-8) +: 8];
   endfunction

   function automatic int find_slot(logic [63:0] lo, logic [31:0] hi, int home);
      int s;
      for (int k = 0; k < SLOTS; k++) begin
         s = (home + k) % SLOTS;
         if (occupancy[s] != 0 && key_low[s] == lo && key_high[s] == hi) return s;
      end
      return -1;
   endfunction

   function automatic rsp_type apply_command(req_type r);
      rsp_type     res;
      int          n, s, home, lim;
      logic [63:0] lo;
      logic [31:0] hi, h;
      lo  = r.name_low;
      hi  = r.name_high;
      lim = (r.name_length > 12) ? 12 : r.name_length;
      n   = lim;
      for (int i = 0; i < lim; i++)
         if (char_of(lo, hi, i) == 8'd0) begin
            n = i;
            break;
         end
      // mask off characters beyond effective length
      for (int i = 0; i < 12; i++)
         if (i >= n) begin
            if (i < 8) lo[8*i +: 8] = 8'd0;
            else       hi[8*(i-8) +: 8] = 8'd0;
         end
      h = HASH_SEED;
      for (int i = 0; i < n; i++) h = h * HASH_MULT + 32'(char_of(lo, hi, i));
      home = int'(h % SLOTS);
      res.status       = ST_OK;
      res.found_handle = '0;
      case (cmd_type'(r.cmd))
         CMD_INSERT: begin
            s = find_slot(lo, hi, home);
            if (s < 0)
               for (int k = 0; k < SLOTS; k++)
                  if (occupancy[(home + k) % SLOTS] == 0) begin
                     s = (home + k) % SLOTS;
                     break;
                  end
            if (s < 0) res.status = ST_FULL;
            else if (occupancy[s] >= DEPTH) res.status = ST_OVERFLOW;
            else begin
               key_low[s]  = lo;
               key_high[s] = hi;
               lvl[s][occupancy[s]] = r.scope_level;
               hnd[s][occupancy[s]] = r.handle;
               occupancy[s]++;
            end
         end
         CMD_LOOKUP: begin
            s = find_slot(lo, hi, home);
            if (s < 0) res.status = ST_NOT_FOUND;
            else res.found_handle = hnd[s][occupancy[s]-1];
         end
         CMD_CLEAR: begin
            for (int t = 0; t < SLOTS; t++)
               if (occupancy[t] != 0 && lvl[t][occupancy[t]-1] == r.scope_level)
                  occupancy[t]--;
         end
         default: ;
      endcase
      return res;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         for (int s = 0; s < SLOTS; s++) occupancy[s] = 0;
         expected_q.delete();
         fail_count <= 0;
      end else begin
         if (tap.rsp_valid && tap.rsp_ready) begin
            if (expected_q.size() == 0) begin
               $display("%0t: unexpected response %p", $time, tap.rsp_payload);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_q.pop_front();
               if (tap.rsp_payload.status !== want.status ||
                   tap.rsp_payload.found_handle !== want.found_handle) begin
                  $display("%0t: mismatch exp status %0d handle %h, got status %0d handle %h",
                     $time, want.status, want.found_handle,
                     tap.rsp_payload.status, tap.rsp_payload.found_handle);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (tap.req_valid && tap.req_ready)
            expected_q.push_back(apply_command(tap.req_payload));
      end
      pending <= expected_q.size();
   end
endmodule

[dv/tb_top.sv]
`timescale 1ns / 1ps
module tb_top;
   import ssht_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   fail_count;
   int   pending;

   ssht_req_if req_ch ();
   ssht_rsp_if rsp_ch ();
   ssht_tap_if tap ();

   assign tap.req_valid   = req_ch.valid;
   assign tap.req_ready   = req_ch.ready;
   assign tap.req_payload = req_ch.payload;
   assign tap.rsp_valid   = rsp_ch.valid;
   assign tap.rsp_ready   = rsp_ch.ready;
   assign tap.rsp_payload = rsp_ch.payload;

   scoped_symbol_hash_table_top dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch.sink),
      .rsp   (rsp_ch.source)
   );

   ssht_checker #(.SLOTS(64), .DEPTH(4)) u_checker (
      .clock      (clock),
      .reset      (reset),
      .tap        (tap.sink),
      .fail_count (fail_count),
      .pending    (pending)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Small name pool keeps hits, shadowing, overflow and collisions frequent.
   logic [63:0] pool_low  [16];
   logic [31:0] pool_high [16];
   logic [3:0]  pool_len  [16];

   // Issue one transaction and hold it until the DUT accepts it.
   // valid drops only when an idle gap follows.
   task automatic send(cmd_type c, logic [63:0] lo, logic [31:0] hi,
                       logic [3:0] len, logic [7:0] lv, logic [31:0] h);
      int gap;
      gap = $urandom_range(0, 4);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.payload <= '{cmd: c, name_low: lo, name_high: hi,
                          name_length: len, scope_level: lv, handle: h};
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   // Drain: stop sending and wait until every outstanding transaction has responded.
   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   // Response-side backpressure, fresh draw for every transaction.
   initial begin
      int stall;
      rsp_ch.ready = 1'b0;
      @(negedge reset);
      forever begin
         stall = $urandom_range(0, 4);
         if ($urandom_range(0, 3) == 0) stall = 0;
         if (stall != 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_ch.valid) @(posedge clock);
      end
   end

   initial begin
      int p, kind;
      req_ch.valid   = 1'b0;
      req_ch.payload = '0;
      for (int i = 0; i < 16; i++) begin
         pool_len[i]  = 4'($urandom_range(1, 12));
         pool_low[i]  = {$urandom, $urandom} | 64'h0101010101010101;
         pool_high[i] = $urandom | 32'h01010101;
      end
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: extremes, every command, special cases.
      send(CMD_LOOKUP, 64'h61, 32'h0, 4'd1, 8'd0, 32'h0);          // miss on empty table
      send(CMD_INSERT, 64'h61, 32'h0, 4'd1, 8'd0, 32'hFFFFFFFF);
      send(CMD_INSERT, 64'hFF61, 32'hFFFFFFFF, 4'd1, 8'd1, 32'h1); // same name, junk past length
      send(CMD_INSERT, 64'h61, 32'h0, 4'd1, 8'd2, 32'h2);
      send(CMD_INSERT, 64'h61, 32'h0, 4'd1, 8'd255, 32'h3);
      send(CMD_INSERT, 64'h61, 32'h0, 4'd1, 8'd3, 32'h4);          // stack overflow
      send(CMD_LOOKUP, 64'h61, 32'h0, 4'd1, 8'd0, 32'h0);
      send(CMD_CLEAR, 64'h0, 32'h0, 4'd0, 8'd255, 32'h0);
      send(CMD_LOOKUP, 64'h61, 32'h0, 4'd1, 8'd0, 32'h0);
      send(CMD_INSERT, 64'h0, 32'h0, 4'd0, 8'd9, 32'hA5A5A5A5);     // empty name
      send(CMD_INSERT, 64'h6100, 32'h0, 4'd5, 8'd9, 32'h5);         // zero char ends name
      send(CMD_LOOKUP, 64'h0, 32'h0, 4'd15, 8'd0, 32'h0);
      send(CMD_INSERT, 64'hFFFFFFFFFFFFFFFF, 32'hFFFFFFFF, 4'd15, 8'd7, 32'h0);
      send(CMD_LOOKUP, 64'hFFFFFFFFFFFFFFFF, 32'hFFFFFFFF, 4'd12, 8'd0, 32'h0);
      send(CMD_NOP, 64'hFFFFFFFFFFFFFFFF, 32'hFFFFFFFF, 4'd15, 8'hFF, 32'hFFFFFFFF);
      for (int l = 0; l < 4; l++)
         send(CMD_CLEAR, 64'h0, 32'h0, 4'd0, 8'(l == 3 ? 9 : l), 32'h0);
      send(CMD_CLEAR, 64'h0, 32'h0, 4'd0, 8'd7, 32'h0);
      send(CMD_LOOKUP, 64'h61, 32'h0, 4'd1, 8'd0, 32'h0);          // slot still holds levels 0 and 1

      // Fill the table with distinct names to reach table full.
      for (int i = 0; i < 66; i++)
         send(CMD_INSERT, 64'(32'h41414100 + 32'(i) + 32'd1), 32'h0, 4'd4, 8'd200,
              $urandom);
      send(CMD_LOOKUP, 64'h41414105, 32'h0, 4'd4, 8'd0, 32'h0);
      wait_drained();                                              // full-drain pause
      send(CMD_CLEAR, 64'h0, 32'h0, 4'd0, 8'd200, 32'h0);

      // Random: mostly pool names, scoped levels, occasional clears/noise.
      for (int i = 0; i < 1150; i++) begin
         p    = $urandom_range(0, 15);
         kind = $urandom_range(0, 99);
         if (kind < 45)
            send(CMD_INSERT, pool_low[p], pool_high[p], pool_len[p],
                 8'($urandom_range(0, 5)), $urandom);
         else if (kind < 80)
            send(CMD_LOOKUP, pool_low[p], pool_high[p], pool_len[p], 8'd0, 32'h0);
         else if (kind < 92)
            send(CMD_CLEAR, 64'h0, 32'h0, 4'd0, 8'($urandom_range(0, 5)), 32'h0);
         else
            send(cmd_type'($urandom_range(0, 3)), {$urandom, $urandom}, $urandom,
                 4'($urandom), 8'($urandom), $urandom);
      end
      wait_drained();
      repeat (200) @(posedge clock);
      if (fail_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   // Watchdog: far beyond the worst case (~1300 transactions plus stalls).
   initial begin
      #2000000;
      $display("[FAIL] regression broken");
      $finish;
   end
endmodule
